@@ design/pit_pkg.sv @@
// ----------------------------------------------------------------------------
// pit_pkg: shared types and constants for the point-in-triangle test
// Holds the coordinate and intermediate widths, the configuration register
// indexes and the words passed between the pipeline stages.
// ----------------------------------------------------------------------------
package pit_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int SUM_W   = CROSS_W + 1;
    localparam int IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_VERTEX_A_X = 3'd0,
        REG_VERTEX_A_Y = 3'd1,
        REG_VERTEX_B_X = 3'd2,
        REG_VERTEX_B_Y = 3'd3,
        REG_VERTEX_C_X = 3'd4,
        REG_VERTEX_C_Y = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } vertex_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] e0x;
        logic signed [DIFF_W-1:0] e0y;
        logic signed [DIFF_W-1:0] e1x;
        logic signed [DIFF_W-1:0] e1y;
        logic signed [DIFF_W-1:0] wx;
        logic signed [DIFF_W-1:0] wy;
    } diff_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] e0x_e1y;
        logic signed [PROD_W-1:0] e0y_e1x;
        logic signed [PROD_W-1:0] wx_e1y;
        logic signed [PROD_W-1:0] wy_e1x;
        logic signed [PROD_W-1:0] e0x_wy;
        logic signed [PROD_W-1:0] e0y_wx;
    } prod_t;

    typedef struct packed {
        logic signed [CROSS_W-1:0] den;
        logic signed [CROSS_W-1:0] nu;
        logic signed [CROSS_W-1:0] nv;
    } cross_t;

endpackage

@@ design/pit_diff_stage.sv @@
// ----------------------------------------------------------------------------
// pit_diff_stage: edge and point difference vectors
// Forms the edge vectors C - A and B - A and the point offset from vertex A, registered.
// ----------------------------------------------------------------------------
module pit_diff_stage
    import pit_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  vertex_t                   vertex,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    output logic                      out_valid,
    input  logic                      out_ready,
    output diff_t                     out_data
);

    logic  valid_reg;
    diff_t data_reg;
    diff_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.e0x = DIFF_W'(vertex.cx) - DIFF_W'(vertex.ax);
        data_next.e0y = DIFF_W'(vertex.cy) - DIFF_W'(vertex.ay);
        data_next.e1x = DIFF_W'(vertex.bx) - DIFF_W'(vertex.ax);
        data_next.e1y = DIFF_W'(vertex.by) - DIFF_W'(vertex.ay);
        data_next.wx  = DIFF_W'(point_x) - DIFF_W'(vertex.ax);
        data_next.wy  = DIFF_W'(point_y) - DIFF_W'(vertex.ay);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ design/pit_prod_stage.sv @@
// ----------------------------------------------------------------------------
// pit_prod_stage: cross-product terms
// Six signed 17 by 17 bit multiplications, each registered.
// ----------------------------------------------------------------------------
module pit_prod_stage
    import pit_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  diff_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output prod_t out_data
);

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.e0x_e1y = in_data.e0x * in_data.e1y;
        data_next.e0y_e1x = in_data.e0y * in_data.e1x;
        data_next.wx_e1y  = in_data.wx * in_data.e1y;
        data_next.wy_e1x  = in_data.wy * in_data.e1x;
        data_next.e0x_wy  = in_data.e0x * in_data.wy;
        data_next.e0y_wx  = in_data.e0y * in_data.wx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ design/pit_cross_stage.sv @@
// ----------------------------------------------------------------------------
// pit_cross_stage: cross products
// Subtracts the product pairs to give the denominator and both numerators.
// ----------------------------------------------------------------------------
module pit_cross_stage
    import pit_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  prod_t  in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output cross_t out_data
);

    logic   valid_reg;
    cross_t data_reg;
    cross_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.den = CROSS_W'(in_data.e0x_e1y) - CROSS_W'(in_data.e0y_e1x);
        data_next.nu  = CROSS_W'(in_data.wx_e1y) - CROSS_W'(in_data.wy_e1x);
        data_next.nv  = CROSS_W'(in_data.e0x_wy) - CROSS_W'(in_data.e0y_wx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ design/pit_decide_stage.sv @@
// ----------------------------------------------------------------------------
// pit_decide_stage: inside decision and output register
// Compares the numerators and their sum against the signed denominator.
// ----------------------------------------------------------------------------
module pit_decide_stage
    import pit_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  cross_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output logic   out_inside
);

    logic                    valid_reg;
    logic                    inside_reg;
    logic                    inside_next;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] den_ext;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_inside = inside_reg;

    assign sum     = SUM_W'(in_data.nu) + SUM_W'(in_data.nv);
    assign den_ext = SUM_W'(in_data.den);

    always_comb begin
        if (in_data.den > 0) begin
            inside_next = (in_data.nu > 0) && (in_data.nv > 0) && (sum < den_ext);
        end else if (in_data.den < 0) begin
            inside_next = (in_data.nu < 0) && (in_data.nv < 0) && (sum > den_ext);
        end else begin
            inside_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            inside_reg <= inside_next;
        end
    end

endmodule

@@ design/point_in_triangle_test_core.sv @@
// ----------------------------------------------------------------------------
// point_in_triangle_test_core: barycentric point-in-triangle test
// The triangle vertices A, B and C are written through the configuration
// port (indexes 0 to 5: A.x, A.y, B.x, B.y, C.x, C.y; other indexes are
// ignored). Each input word carries one point, and each output word says
// whether that point lies strictly inside the triangle; points on an edge or
// vertex and all points of a degenerate triangle give 0. The test is exact.
// The pipeline has four register stages (differences, products, cross
// products, decision), and one point is accepted every cycle while the
// output is drained.
// Vertices are to be written only while no point is in flight.
// ----------------------------------------------------------------------------
module point_in_triangle_test_core
    import pit_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_inside_res
);

    vertex_t vertex_reg;
    logic    diff_valid;
    logic    prod_valid;
    logic    cross_valid;
    logic    prod_ready;
    logic    cross_ready;
    logic    decide_ready;
    diff_t   diff_data;
    prod_t   prod_data;
    cross_t  cross_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_VERTEX_A_X: vertex_reg.ax <= cfg_data;
                REG_VERTEX_A_Y: vertex_reg.ay <= cfg_data;
                REG_VERTEX_B_X: vertex_reg.bx <= cfg_data;
                REG_VERTEX_B_Y: vertex_reg.by <= cfg_data;
                REG_VERTEX_C_X: vertex_reg.cx <= cfg_data;
                REG_VERTEX_C_Y: vertex_reg.cy <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    pit_diff_stage u_diff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .vertex    (vertex_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .point_x   (s_point_x),
        .point_y   (s_point_y),
        .out_valid (diff_valid),
        .out_ready (prod_ready),
        .out_data  (diff_data)
    );

    pit_prod_stage u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (diff_valid),
        .in_ready  (prod_ready),
        .in_data   (diff_data),
        .out_valid (prod_valid),
        .out_ready (cross_ready),
        .out_data  (prod_data)
    );

    pit_cross_stage u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (cross_ready),
        .in_data   (prod_data),
        .out_valid (cross_valid),
        .out_ready (decide_ready),
        .out_data  (cross_data)
    );

    pit_decide_stage u_decide (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (cross_valid),
        .in_ready   (decide_ready),
        .in_data    (cross_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_inside (m_inside_res)
    );

    // A reset leaves no word in the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // An accepted point is held in the first stage on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> diff_valid)
        else $error("accepted point lost in the first stage");

    // A full pipeline with a stalled output takes no new point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        diff_valid && prod_valid && cross_valid && m_valid && !m_ready |-> !s_ready)
        else $error("full pipeline accepted a point");

endmodule

@@ tb/sv/point_in_triangle_test_core_tb.sv @@
// ----------------------------------------------------------------------------
// point_in_triangle_test_core_tb: self-checking bench for the triangle test
// Programs a series of triangles through the vertex registers and streams
// query points through the valid/ready channels. A scoreboard works out the
// inside flag of every accepted point with exact 64-bit arithmetic and
// compares it with each returned word in order. The run covers hand-picked
// vertices, edges, windings, extremes and degenerate triangles, followed by
// random triangles and points under several idle and stall patterns.
// ----------------------------------------------------------------------------
module point_in_triangle_test_core_tb;
    import pit_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int PIPE_LATENCY = 4;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 10;

    typedef logic signed [COORD_W-1:0] coord_t;

    class triangle_scoreboard;
        coord_t vert [6];
        bit     pending_inside [$];
        int     mismatch_count;
        int     checked_count;
        int     inside_count;

        function new();
            foreach (vert[i]) vert[i] = '0;
            mismatch_count = 0;
            checked_count  = 0;
            inside_count   = 0;
        endfunction

        function void write_vertex(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] value);
            if (idx <= REG_VERTEX_C_Y) begin
                vert[idx] = value;
            end
        endfunction

        function bit point_is_inside(coord_t px, coord_t py);
            longint ax, ay, e0x, e0y, e1x, e1y, wx, wy, den, nu, nv;
            ax  = longint'(vert[REG_VERTEX_A_X]);
            ay  = longint'(vert[REG_VERTEX_A_Y]);
            e0x = longint'(vert[REG_VERTEX_C_X]) - ax;
            e0y = longint'(vert[REG_VERTEX_C_Y]) - ay;
            e1x = longint'(vert[REG_VERTEX_B_X]) - ax;
            e1y = longint'(vert[REG_VERTEX_B_Y]) - ay;
            wx  = longint'(px) - ax;
            wy  = longint'(py) - ay;
            den = e0x * e1y - e0y * e1x;
            nu  = wx * e1y - wy * e1x;
            nv  = e0x * wy - e0y * wx;
            if (den > 0) begin
                return (nu > 0) && (nv > 0) && (nu + nv < den);
            end else if (den < 0) begin
                return (nu < 0) && (nv < 0) && (nu + nv > den);
            end
            return 1'b0;
        endfunction

        function void note_point(coord_t px, coord_t py);
            pending_inside.push_back(point_is_inside(px, py));
        endfunction

        function void check_result(logic got);
            bit want;
            if (pending_inside.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("ERROR: result word with no point outstanding, inside_res=%b", got);
                end
                return;
            end
            want = pending_inside.pop_front();
            checked_count++;
            if (want) begin
                inside_count++;
            end
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("ERROR: word %0d inside_res expected %b, got %b",
                             checked_count, want, got);
                end
            end
        endfunction

        function int outstanding();
            return pending_inside.size();
        endfunction

        function void close_out();
            if (pending_inside.size() != 0) begin
                mismatch_count += pending_inside.size();
                $display("ERROR: %0d expected words never arrived", pending_inside.size());
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [COORD_W-1:0] cfg_data;
    logic               s_valid;
    logic               s_ready;
    coord_t             s_point_x;
    coord_t             s_point_y;
    logic               m_valid;
    logic               m_ready;
    logic               m_inside_res;

    triangle_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int triangle_count;
    int point_count;

    point_in_triangle_test_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res)
    );

    initial begin
        aclk = 1'b0;
    end

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_inside_res);
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return coord_t'(v);
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        sb.write_vertex(idx, value);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic program_triangle(input coord_t ax, input coord_t ay, input coord_t bx,
                                    input coord_t by, input coord_t cx, input coord_t cy,
                                    input bit spare);
        settle();
        write_reg(REG_VERTEX_A_X, ax);
        write_reg(REG_VERTEX_A_Y, ay);
        write_reg(REG_VERTEX_B_X, bx);
        write_reg(REG_VERTEX_B_Y, by);
        write_reg(REG_VERTEX_C_X, cx);
        write_reg(REG_VERTEX_C_Y, cy);
        if (spare) begin
            write_reg(REG_SPARE_6, 16'($urandom));
            write_reg(REG_SPARE_7, 16'($urandom));
        end
        cfg_we <= 1'b0;
        triangle_count++;
    endtask

    task automatic send_point(input coord_t px, input coord_t py);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid   <= 1'b1;
        s_point_x <= px;
        s_point_y <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_point(px, py);
        point_count++;
    endtask

    task automatic program_random_triangle();
        coord_t v [6];
        longint cxn, cyn, span;
        int kind, k;
        kind = pick(0, 9);
        if (kind < 3) begin
            foreach (v[i]) v[i] = coord_t'($urandom);
        end else if (kind < 7) begin
            cxn  = longint'(coord_t'($urandom));
            cyn  = longint'(coord_t'($urandom));
            span = longint'(1) << pick(1, 13);
            for (int i = 0; i < 6; i += 2) begin
                v[i]     = clamp_coord(cxn + longint'($urandom_range(2 * span)) - span);
                v[i + 1] = clamp_coord(cyn + longint'($urandom_range(2 * span)) - span);
            end
        end else if (kind < 9) begin
            // Collinear or coincident vertices: C lies on the line through A and B.
            k    = pick(-2, 3);
            v[0] = coord_t'(pick(-8000, 8000));
            v[1] = coord_t'(pick(-8000, 8000));
            v[2] = coord_t'(v[0] + pick(-100, 100));
            v[3] = coord_t'(v[1] + pick(-100, 100));
            v[4] = coord_t'(v[0] + k * (v[2] - v[0]));
            v[5] = coord_t'(v[1] + k * (v[3] - v[1]));
        end else begin
            foreach (v[i]) v[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end
        program_triangle(v[0], v[1], v[2], v[3], v[4], v[5], pick(0, 3) == 0);
    endtask

    task automatic send_random_point();
        longint xs [3];
        longint ys [3];
        longint wa, wb, wc, tot;
        coord_t px, py;
        int kind, a, b;
        xs[0] = longint'(sb.vert[REG_VERTEX_A_X]);
        ys[0] = longint'(sb.vert[REG_VERTEX_A_Y]);
        xs[1] = longint'(sb.vert[REG_VERTEX_B_X]);
        ys[1] = longint'(sb.vert[REG_VERTEX_B_Y]);
        xs[2] = longint'(sb.vert[REG_VERTEX_C_X]);
        ys[2] = longint'(sb.vert[REG_VERTEX_C_Y]);
        kind = pick(0, 99);
        if (kind < 55) begin
            wa  = pick(0, 1023);
            wb  = pick(0, 1023);
            wc  = pick(0, 1023);
            tot = wa + wb + wc;
            if (tot == 0) begin
                wa  = 1;
                tot = 1;
            end
            px = coord_t'((wa * xs[0] + wb * xs[1] + wc * xs[2]) / tot);
            py = coord_t'((wa * ys[0] + wb * ys[1] + wc * ys[2]) / tot);
        end else if (kind < 65) begin
            a  = pick(0, 2);
            px = coord_t'(xs[a]);
            py = coord_t'(ys[a]);
        end else if (kind < 78) begin
            a  = pick(0, 2);
            b  = (a + 1) % 3;
            px = clamp_coord(((xs[a] + xs[b]) >>> 1) + pick(-1, 1) * pick(0, 1));
            py = clamp_coord(((ys[a] + ys[b]) >>> 1) + pick(-1, 1) * pick(0, 1));
        end else begin
            px = coord_t'($urandom);
            py = coord_t'($urandom);
        end
        send_point(px, py);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int triangles);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (triangles) begin
            program_random_triangle();
            repeat (pick(60, 92)) begin
                if (pick(0, 149) == 0) begin
                    settle();
                end
                send_random_point();
            end
        end
    endtask

    initial begin
        sb             = new();
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_point_x      = '0;
        s_point_y      = '0;
        m_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_count    = 0;
        triangle_count = 0;
        point_count    = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // All vertices reset to the origin, so the triangle is degenerate.
        send_point(0, 0);
        send_point(1, -1);

        program_triangle(0, 0, 0, 100, 100, 0, 1'b0);
        send_point(10, 10);
        send_point(33, 33);
        send_point(50, 50);
        send_point(0, 50);
        send_point(0, 0);
        send_point(100, 0);
        send_point(-1, 10);
        send_point(32767, 32767);
        send_point(-32768, -32768);

        // Same triangle with the opposite winding.
        program_triangle(0, 0, 100, 0, 0, 100, 1'b0);
        send_point(10, 10);
        send_point(50, 50);
        send_point(60, 60);

        // Full-range triangle; the spare register writes must leave it intact.
        program_triangle(-32768, -32768, 32767, -32768, -32768, 32767, 1'b1);
        send_point(-1, -1);
        send_point(0, 0);
        send_point(-32767, 32766);
        send_point(-32767, -32767);
        send_point(-32768, -32768);
        send_point(32767, 32767);

        program_triangle(-5, -5, 0, 0, 5, 5, 1'b0);
        send_point(0, 0);
        send_point(1, 0);

        run_random_phase(0, 0, 6);
        run_random_phase(68, 0, 6);
        run_random_phase(0, 68, 6);
        run_random_phase(37, 37, 6);
        settle();

        sb.close_out();
        $display("Tested %0d points over %0d triangle settings, %0d of them inside.",
                 point_count, triangle_count, sb.inside_count);
        $display("Checked %0d result words, %0d mismatches.",
                 sb.checked_count, sb.mismatch_count);
        if (sb.mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/pit_pkg.sv
design/pit_diff_stage.sv
design/pit_prod_stage.sv
design/pit_cross_stage.sv
design/pit_decide_stage.sv
design/point_in_triangle_test_core.sv
tb/sv/point_in_triangle_test_core_tb.sv
